### src/murmur_keystream_xor_decrypt_unit_defines.svh
// Assertion macros for the murmur keystream XOR decrypt unit.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MURMUR_KEYSTREAM_XOR_DECRYPT_UNIT_DEFINES_SVH
`define MURMUR_KEYSTREAM_XOR_DECRYPT_UNIT_DEFINES_SVH

// same-cycle implication
`define MKX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MKX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mkx_pkg.sv
// Shared types, constants and arithmetic helpers for the keystream decrypt unit.
// No dependencies.
`default_nettype none

package mkx_pkg;

  localparam int WORD_W      = 32;
  localparam int HASH_W      = 64;
  localparam int NUM_WORDS   = 8;
  localparam int LANE_STAGES = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_ONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_TWO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_THREE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED   = 2'd3;

  localparam logic [HASH_W-1:0] MUR_C1      = 64'h87c3_7b91_1142_53d5;
  localparam logic [HASH_W-1:0] MUR_C2      = 64'h4cf5_ad43_2745_937f;
  localparam logic [HASH_W-1:0] FMIX_M1     = 64'hff51_afd7_ed55_8ccd;
  localparam logic [HASH_W-1:0] FMIX_M2     = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [HASH_W-1:0] MIX_ADD1    = 64'h0000_0000_52dc_e729;
  localparam logic [HASH_W-1:0] MIX_ADD2    = 64'h0000_0000_3849_5ab5;
  localparam logic [HASH_W-1:0] BLOCK_BYTES = 64'd16;

  // 64x64 low product split into 32-bit partial products
  typedef struct packed {
    logic [HASH_W-1:0] lo;
    logic [WORD_W-1:0] m1;
    logic [WORD_W-1:0] m2;
  } pp_t;

  typedef struct packed {
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
    pp_t               pa;
    pp_t               pb;
  } lane_t;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] words_t;

  function automatic logic [HASH_W-1:0] rotl64(input logic [HASH_W-1:0] x, input int r);
    return (x << r) | (x >> (HASH_W - r));
  endfunction

  function automatic pp_t mul_pp(input logic [HASH_W-1:0] x, input logic [HASH_W-1:0] c);
    logic [WORD_W-1:0] xl;
    logic [WORD_W-1:0] xh;
    logic [WORD_W-1:0] cl;
    logic [WORD_W-1:0] ch;
    pp_t               p;
    xl   = x[WORD_W-1:0];
    xh   = x[HASH_W-1:WORD_W];
    cl   = c[WORD_W-1:0];
    ch   = c[HASH_W-1:WORD_W];
    p.lo = HASH_W'(xl) * HASH_W'(cl);
    p.m1 = xh * cl;
    p.m2 = xl * ch;
    return p;
  endfunction

  function automatic logic [HASH_W-1:0] mul_sum(input pp_t p);
    logic [WORD_W-1:0] mid;
    mid = p.m1 + p.m2;
    return p.lo + {mid, {WORD_W{1'b0}}};
  endfunction

  function automatic logic [HASH_W-1:0] fold33(input logic [HASH_W-1:0] x);
    return x ^ (x >> 33);
  endfunction

endpackage

`default_nettype wire

### src/mkx_hash_lane.sv
// One MurmurHash3 x64-128 lane for a single 16-byte block, 16 register stages.
// Depends on mkx_pkg; stage enables come from the top level's flow control.
`default_nettype none

module mkx_hash_lane (
  input  logic                                clk,
  input  logic [mkx_pkg::LANE_STAGES-1:0]     stage_en,
  input  logic [mkx_pkg::WORD_W-1:0]          key_word,
  input  logic [mkx_pkg::WORD_W-1:0]          fixed_one,
  input  logic [mkx_pkg::WORD_W-1:0]          fixed_two,
  input  logic [mkx_pkg::WORD_W-1:0]          fixed_three,
  input  logic [mkx_pkg::WORD_W-1:0]          seed,
  output logic [mkx_pkg::HASH_W-1:0]          hash_h1,
  output logic [mkx_pkg::HASH_W-1:0]          hash_h2
);

  mkx_pkg::lane_t st_r   [mkx_pkg::LANE_STAGES];
  mkx_pkg::lane_t st_nxt [mkx_pkg::LANE_STAGES];

  always_comb begin
    logic [mkx_pkg::HASH_W-1:0] seed64;
    logic [mkx_pkg::HASH_W-1:0] fa;
    logic [mkx_pkg::HASH_W-1:0] fb;
    seed64 = {{(mkx_pkg::HASH_W - mkx_pkg::WORD_W){1'b0}}, seed};
    fa     = mkx_pkg::fold33(st_r[13].a);
    fb     = mkx_pkg::fold33(st_r[13].b);

    st_nxt[0] = '0;
    for (int j = 1; j < mkx_pkg::LANE_STAGES; j++) begin
      st_nxt[j] = st_r[j-1];
    end

    // body: k1 = k1 * c1, k2 = k2 * c2
    st_nxt[0].pa = mkx_pkg::mul_pp({fixed_one, key_word}, mkx_pkg::MUR_C1);
    st_nxt[0].pb = mkx_pkg::mul_pp({fixed_three, fixed_two}, mkx_pkg::MUR_C2);
    st_nxt[1].a  = mkx_pkg::mul_sum(st_r[0].pa);
    st_nxt[1].b  = mkx_pkg::mul_sum(st_r[0].pb);
    st_nxt[2].pa = mkx_pkg::mul_pp(mkx_pkg::rotl64(st_r[1].a, 31), mkx_pkg::MUR_C2);
    st_nxt[2].pb = mkx_pkg::mul_pp(mkx_pkg::rotl64(st_r[1].b, 33), mkx_pkg::MUR_C1);
    st_nxt[3].a  = mkx_pkg::mul_sum(st_r[2].pa);
    st_nxt[3].b  = mkx_pkg::mul_sum(st_r[2].pb);
    st_nxt[4].a  = mkx_pkg::rotl64(seed64 ^ st_r[3].a, 27) + seed64;
    st_nxt[4].b  = mkx_pkg::rotl64(seed64 ^ st_r[3].b, 31);
    st_nxt[5].a  = (st_r[4].a << 2) + st_r[4].a + mkx_pkg::MIX_ADD1;
    st_nxt[6].b  = st_r[5].b + st_r[5].a;
    st_nxt[7].a  = st_r[6].a ^ mkx_pkg::BLOCK_BYTES;
    st_nxt[7].b  = ((st_r[6].b << 2) + st_r[6].b + mkx_pkg::MIX_ADD2) ^ mkx_pkg::BLOCK_BYTES;
    // finalization
    st_nxt[8].a  = st_r[7].a + st_r[7].b;
    st_nxt[9].b  = st_r[8].b + st_r[8].a;
    st_nxt[10].pa = mkx_pkg::mul_pp(mkx_pkg::fold33(st_r[9].a), mkx_pkg::FMIX_M1);
    st_nxt[10].pb = mkx_pkg::mul_pp(mkx_pkg::fold33(st_r[9].b), mkx_pkg::FMIX_M1);
    st_nxt[11].a  = mkx_pkg::mul_sum(st_r[10].pa);
    st_nxt[11].b  = mkx_pkg::mul_sum(st_r[10].pb);
    st_nxt[12].pa = mkx_pkg::mul_pp(mkx_pkg::fold33(st_r[11].a), mkx_pkg::FMIX_M2);
    st_nxt[12].pb = mkx_pkg::mul_pp(mkx_pkg::fold33(st_r[11].b), mkx_pkg::FMIX_M2);
    st_nxt[13].a  = mkx_pkg::mul_sum(st_r[12].pa);
    st_nxt[13].b  = mkx_pkg::mul_sum(st_r[12].pb);
    st_nxt[14].a  = fa + fb;
    st_nxt[14].b  = fb;
    st_nxt[15].b  = st_r[14].b + st_r[14].a;
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < mkx_pkg::LANE_STAGES; j++) begin
      if (stage_en[j]) begin
        st_r[j] <= st_nxt[j];
      end
    end
  end

  assign hash_h1 = st_r[mkx_pkg::LANE_STAGES-1].a;
  assign hash_h2 = st_r[mkx_pkg::LANE_STAGES-1].b;

endmodule

`default_nettype wire

### src/murmur_keystream_xor_decrypt_unit.sv
// Keystream XOR decrypt unit: two MurmurHash3 x64-128 lanes and an output XOR stage.
// Depends on mkx_pkg, mkx_hash_lane and the assertion macro header.
//
// One item per clock sustained while out_stall stays low. An accepted beat shows up
// on out_valid after passing 16 lane stages (each 64-bit multiply is one stage of
// 32x32 partial products and one stage of summing) and the output register. Stages
// with no valid beat are filled while the output is stalled, so in_stall rises only
// once all stages and the output register hold beats. cfg_ready is always high; the user
// must write registers only while the unit is empty; the unit itself does not enforce it.
`default_nettype none
`include "murmur_keystream_xor_decrypt_unit_defines.svh"

module murmur_keystream_xor_decrypt_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mkx_pkg::WORD_W-1:0]         in_key_first,
  input  logic [mkx_pkg::WORD_W-1:0]         in_key_second,
  input  logic [mkx_pkg::WORD_W-1:0]         in_cipher_word_0,
  input  logic [mkx_pkg::WORD_W-1:0]         in_cipher_word_1,
  input  logic [mkx_pkg::WORD_W-1:0]         in_cipher_word_2,
  input  logic [mkx_pkg::WORD_W-1:0]         in_cipher_word_3,
  input  logic [mkx_pkg::WORD_W-1:0]         in_cipher_word_4,
  input  logic [mkx_pkg::WORD_W-1:0]         in_cipher_word_5,
  input  logic [mkx_pkg::WORD_W-1:0]         in_cipher_word_6,
  input  logic [mkx_pkg::WORD_W-1:0]         in_cipher_word_7,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mkx_pkg::WORD_W-1:0]         out_plain_word_0,
  output logic [mkx_pkg::WORD_W-1:0]         out_plain_word_1,
  output logic [mkx_pkg::WORD_W-1:0]         out_plain_word_2,
  output logic [mkx_pkg::WORD_W-1:0]         out_plain_word_3,
  output logic [mkx_pkg::WORD_W-1:0]         out_plain_word_4,
  output logic [mkx_pkg::WORD_W-1:0]         out_plain_word_5,
  output logic [mkx_pkg::WORD_W-1:0]         out_plain_word_6,
  output logic [mkx_pkg::WORD_W-1:0]         out_plain_word_7,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mkx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mkx_pkg::WORD_W-1:0]         cfg_data
);

  localparam int NS = mkx_pkg::LANE_STAGES;

  logic [mkx_pkg::WORD_W-1:0] fixed_one_r;
  logic [mkx_pkg::WORD_W-1:0] fixed_two_r;
  logic [mkx_pkg::WORD_W-1:0] fixed_three_r;
  logic [mkx_pkg::WORD_W-1:0] seed_r;

  logic [NS:0]               adv;
  logic [NS-1:0]             vld_r;
  mkx_pkg::words_t           data_r [NS];
  mkx_pkg::words_t           cipher_in;
  mkx_pkg::words_t           plain_r;
  mkx_pkg::words_t           plain_nxt;
  logic                      out_valid_r;
  logic [mkx_pkg::HASH_W-1:0] ha_h1;
  logic [mkx_pkg::HASH_W-1:0] ha_h2;
  logic [mkx_pkg::HASH_W-1:0] hb_h1;
  logic [mkx_pkg::HASH_W-1:0] hb_h2;
  logic                      in_acc;
  logic                      out_acc;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_one_r   <= '0;
      fixed_two_r   <= '0;
      fixed_three_r <= '0;
      seed_r        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mkx_pkg::CFG_FIXED_ONE:   fixed_one_r   <= cfg_data;
        mkx_pkg::CFG_FIXED_TWO:   fixed_two_r   <= cfg_data;
        mkx_pkg::CFG_FIXED_THREE: fixed_three_r <= cfg_data;
        mkx_pkg::CFG_HASH_SEED:   seed_r        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // flow control: a stage moves when empty or when the next one moves
  always_comb begin
    adv[NS] = !out_valid_r || !out_stall;
    for (int j = NS - 1; j >= 0; j--) begin
      adv[j] = !vld_r[j] || adv[j+1];
    end
  end

  assign in_stall = !adv[0];
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int j = 1; j < NS; j++) begin
        if (adv[j]) begin
          vld_r[j] <= vld_r[j-1];
        end
      end
      if (adv[NS]) begin
        out_valid_r <= vld_r[NS-1];
      end
    end
  end

  assign cipher_in = {in_cipher_word_7, in_cipher_word_6, in_cipher_word_5, in_cipher_word_4,
                      in_cipher_word_3, in_cipher_word_2, in_cipher_word_1, in_cipher_word_0};

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      data_r[0] <= cipher_in;
    end
    for (int j = 1; j < NS; j++) begin
      if (adv[j]) begin
        data_r[j] <= data_r[j-1];
      end
    end
    if (adv[NS]) begin
      plain_r <= plain_nxt;
    end
  end

  mkx_hash_lane u_lane_a (
    .clk         (clk),
    .stage_en    (adv[NS-1:0]),
    .key_word    (in_key_first),
    .fixed_one   (fixed_one_r),
    .fixed_two   (fixed_two_r),
    .fixed_three (fixed_three_r),
    .seed        (seed_r),
    .hash_h1     (ha_h1),
    .hash_h2     (ha_h2)
  );

  mkx_hash_lane u_lane_b (
    .clk         (clk),
    .stage_en    (adv[NS-1:0]),
    .key_word    (in_key_second),
    .fixed_one   (fixed_one_r),
    .fixed_two   (fixed_two_r),
    .fixed_three (fixed_three_r),
    .seed        (seed_r),
    .hash_h1     (hb_h1),
    .hash_h2     (hb_h2)
  );

  assign plain_nxt = data_r[NS-1] ^ {hb_h2, hb_h1, ha_h2, ha_h1};

  assign out_valid        = out_valid_r;
  assign out_plain_word_0 = plain_r[0];
  assign out_plain_word_1 = plain_r[1];
  assign out_plain_word_2 = plain_r[2];
  assign out_plain_word_3 = plain_r[3];
  assign out_plain_word_4 = plain_r[4];
  assign out_plain_word_5 = plain_r[5];
  assign out_plain_word_6 = plain_r[6];
  assign out_plain_word_7 = plain_r[7];

  `MKX_ASSERT_NOW(a_stall_only_when_full, in_stall, (&vld_r) && out_valid_r && out_stall, "input stalled with a free stage")
  `MKX_ASSERT_NEXT(a_accept_enters, in_acc, vld_r[0], "accepted beat missing from first stage")
  `MKX_ASSERT_NEXT(a_beat_count, 1'b1, $countones({vld_r, out_valid_r}) + int'($past(out_acc)) == $past($countones({vld_r, out_valid_r})) + int'($past(in_acc)), "beat lost or duplicated in pipeline")

endmodule

`default_nettype wire

### sim/plaintext_checker.sv
// Plaintext checker for the keystream XOR decrypt unit: tracks register writes,
// predicts each plaintext beat from MurmurHash3 x64-128 keystreams and compares.
// Depends on mkx_pkg for the shared word types and register index codes.
module plaintext_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [mkx_pkg::WORD_W-1:0]    in_key_first,
  input  logic [mkx_pkg::WORD_W-1:0]    in_key_second,
  input  mkx_pkg::words_t               in_cipher,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  mkx_pkg::words_t               out_plain,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [mkx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mkx_pkg::WORD_W-1:0]    cfg_data,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] MIX_K1  = 64'h87c37b91114253d5;
  localparam logic [63:0] MIX_K2  = 64'h4cf5ad432745937f;
  localparam logic [63:0] AVAL_M1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] AVAL_M2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] KEY_LEN = 64'd16;

  logic [31:0]     fixed_one;
  logic [31:0]     fixed_two;
  logic [31:0]     fixed_three;
  logic [31:0]     seed_reg;
  mkx_pkg::words_t plaintext_due [$];
  mkx_pkg::words_t due;
  int              errors;

  function automatic logic [63:0] rol64(input logic [63:0] v, input int unsigned n);
    return (v << n) | (v >> (64 - n));
  endfunction

  function automatic logic [63:0] avalanche64(input logic [63:0] k);
    logic [63:0] x;
    x = k ^ (k >> 33);
    x = x * AVAL_M1;
    x = x ^ (x >> 33);
    x = x * AVAL_M2;
    return x ^ (x >> 33);
  endfunction

  // returns {h2, h1} for one 16-byte key block
  function automatic logic [127:0] keystream_block(input logic [31:0] lead_word);
    logic [63:0] h1;
    logic [63:0] h2;
    logic [63:0] k1;
    logic [63:0] k2;
    h1 = {32'd0, seed_reg};
    h2 = h1;
    k1 = {fixed_one, lead_word};
    k2 = {fixed_three, fixed_two};
    k1 = k1 * MIX_K1;
    k1 = rol64(k1, 31);
    k1 = k1 * MIX_K2;
    h1 = h1 ^ k1;
    h1 = rol64(h1, 27);
    h1 = h1 + h2;
    h1 = h1 * 64'd5 + 64'h52dce729;
    k2 = k2 * MIX_K2;
    k2 = rol64(k2, 33);
    k2 = k2 * MIX_K1;
    h2 = h2 ^ k2;
    h2 = rol64(h2, 31);
    h2 = h2 + h1;
    h2 = h2 * 64'd5 + 64'h38495ab5;
    h1 = h1 ^ KEY_LEN;
    h2 = h2 ^ KEY_LEN;
    h1 = h1 + h2;
    h2 = h2 + h1;
    h1 = avalanche64(h1);
    h2 = avalanche64(h2);
    h1 = h1 + h2;
    h2 = h2 + h1;
    return {h2, h1};
  endfunction

  function automatic mkx_pkg::words_t expected_plaintext(input logic [31:0] key_a,
                                                         input logic [31:0] key_b,
                                                         input mkx_pkg::words_t cipher);
    logic [255:0] stream;
    stream = {keystream_block(key_b), keystream_block(key_a)};
    return mkx_pkg::words_t'(stream) ^ cipher;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fixed_one   = '0;
      fixed_two   = '0;
      fixed_three = '0;
      seed_reg    = '0;
      plaintext_due.delete();
      errors      = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mkx_pkg::CFG_FIXED_ONE:   fixed_one   = cfg_data;
          mkx_pkg::CFG_FIXED_TWO:   fixed_two   = cfg_data;
          mkx_pkg::CFG_FIXED_THREE: fixed_three = cfg_data;
          mkx_pkg::CFG_HASH_SEED:   seed_reg    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        plaintext_due.push_back(expected_plaintext(in_key_first, in_key_second, in_cipher));
      if (out_valid && !out_stall) begin
        if (plaintext_due.size() == 0) begin
          $error("plaintext beat with nothing expected");
          errors++;
        end else begin
          due = plaintext_due.pop_front();
          for (int i = 0; i < mkx_pkg::NUM_WORDS; i++) begin
            if (out_plain[i] !== due[i]) begin
              $error("plain_word_%0d: expected %08h, got %08h", i, due[i], out_plain[i]);
              errors++;
            end
          end
        end
      end
    end
    pending    <= plaintext_due.size();
    fail_count <= errors;
  end

endmodule

### sim/murmur_keystream_xor_decrypt_unit_tb.sv
// Testbench top for murmur_keystream_xor_decrypt_unit: clock, reset, register
// settings, directed and random cipher beats under idle/stall mixes, verdict.
// Depends on mkx_pkg, the unit under test and plaintext_checker.
module murmur_keystream_xor_decrypt_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASE_BEATS = 100;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [mkx_pkg::WORD_W-1:0]    in_key_first;
  logic [mkx_pkg::WORD_W-1:0]    in_key_second;
  mkx_pkg::words_t               cipher_words;
  logic                          out_valid;
  logic                          out_stall;
  wire  [mkx_pkg::NUM_WORDS-1:0][mkx_pkg::WORD_W-1:0] plain_words;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [mkx_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mkx_pkg::WORD_W-1:0]    cfg_data;
  int                            fail_count;
  int                            pending;
  int                            sender_gap_pct;
  int                            stall_pct;
  int                            beats_sent;
  int                            settings_loaded;
  int                            cycle_count;

  murmur_keystream_xor_decrypt_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_first     (in_key_first),
    .in_key_second    (in_key_second),
    .in_cipher_word_0 (cipher_words[0]),
    .in_cipher_word_1 (cipher_words[1]),
    .in_cipher_word_2 (cipher_words[2]),
    .in_cipher_word_3 (cipher_words[3]),
    .in_cipher_word_4 (cipher_words[4]),
    .in_cipher_word_5 (cipher_words[5]),
    .in_cipher_word_6 (cipher_words[6]),
    .in_cipher_word_7 (cipher_words[7]),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_plain_word_0 (plain_words[0]),
    .out_plain_word_1 (plain_words[1]),
    .out_plain_word_2 (plain_words[2]),
    .out_plain_word_3 (plain_words[3]),
    .out_plain_word_4 (plain_words[4]),
    .out_plain_word_5 (plain_words[5]),
    .out_plain_word_6 (plain_words[6]),
    .out_plain_word_7 (plain_words[7]),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  plaintext_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_key_first  (in_key_first),
    .in_key_second (in_key_second),
    .in_cipher     (cipher_words),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_plain     (plain_words),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] random_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic mkx_pkg::words_t random_cipher();
    mkx_pkg::words_t blk;
    for (int i = 0; i < mkx_pkg::NUM_WORDS; i++)
      blk[i] = random_word();
    return blk;
  endfunction

  task automatic send_cipher_beat(input logic [31:0] key_a, input logic [31:0] key_b,
                                  input mkx_pkg::words_t blk);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_key_first  <= key_a;
    in_key_second <= key_b;
    cipher_words  <= blk;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (24) @(posedge clk);
  endtask

  task automatic reg_write_beat(input logic [mkx_pkg::CFG_IDX_W-1:0] idx,
                                input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_key_settings(input logic [31:0] one, input logic [31:0] two,
                                   input logic [31:0] three, input logic [31:0] seed);
    reg_write_beat(mkx_pkg::CFG_FIXED_ONE, one);
    reg_write_beat(mkx_pkg::CFG_FIXED_TWO, two);
    reg_write_beat(mkx_pkg::CFG_FIXED_THREE, three);
    reg_write_beat(mkx_pkg::CFG_HASH_SEED, seed);
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  initial begin
    logic [31:0]     key_a;
    logic [31:0]     key_b;
    mkx_pkg::words_t blk;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_key_first    = '0;
    in_key_second   = '0;
    cipher_words    = '0;
    cfg_valid       = 1'b0;
    cfg_index       = mkx_pkg::CFG_FIXED_ONE;
    cfg_data        = '0;
    sender_gap_pct  = 0;
    stall_pct       = 0;
    beats_sent      = 0;
    settings_loaded = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats under reset register values
    send_cipher_beat(32'h0, 32'h0, '0);
    send_cipher_beat(32'hffff_ffff, 32'hffff_ffff, '1);
    send_cipher_beat(32'h0, 32'h0, '1);
    send_cipher_beat(32'hffff_ffff, 32'hffff_ffff, '0);
    send_cipher_beat(32'h0, 32'hffff_ffff, {4{64'haaaa_aaaa_5555_5555}});
    send_cipher_beat(32'h1, 32'h8000_0000, {4{64'h5555_5555_aaaa_aaaa}});
    key_a = $urandom;
    send_cipher_beat(key_a, key_a, random_cipher());
    for (int i = 0; i < 12; i++) begin
      key_a = 32'h1 << $urandom_range(31);
      send_cipher_beat(key_a, ~key_a, random_cipher());
    end

    for (int phase = 0; phase < 6; phase++) begin
      drain_pipeline();
      case (phase)
        0: load_key_settings('1, '1, '1, '1);
        1: load_key_settings($urandom, $urandom, $urandom, $urandom);
        2: load_key_settings('0, '1, '0, '1);
        3: load_key_settings('1, '0, '1, '0);
        4: load_key_settings($urandom, $urandom, $urandom, 32'h1);
        default: load_key_settings($urandom, $urandom, $urandom, $urandom);
      endcase
      case (phase)
        1:       begin sender_gap_pct = 50; stall_pct <= 0;  end
        2:       begin sender_gap_pct = 0;  stall_pct <= 50; end
        3, 4:    begin sender_gap_pct = 23; stall_pct <= 23; end
        default: begin sender_gap_pct = 0;  stall_pct <= 0;  end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        key_a = random_word();
        key_b = ($urandom_range(7) == 0) ? key_a : random_word();
        blk   = random_cipher();
        send_cipher_beat(key_a, key_b, blk);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);

    $display("Decrypted %0d cipher beats across reset values and %0d register settings,",
             beats_sent, settings_loaded);
    $display("with back-to-back, sender-idle, receiver-stall and mixed traffic.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/mkx_pkg.sv
src/mkx_hash_lane.sv
src/murmur_keystream_xor_decrypt_unit.sv
sim/plaintext_checker.sv
sim/murmur_keystream_xor_decrypt_unit_tb.sv
